// ----- rtl/mbe_pkg.sv -----
package mbe_pkg;

    // field widths fixed by the interface
    localparam int PIX_BITS   = 15;
    localparam int SPAN_BITS  = 63;
    localparam int COORD_BITS = 64;
    localparam int ITER_BITS  = 27;
    localparam int FMAG_BITS  = 64;

    // iteration loop: number of register stages and order tag width
    localparam int RING_DEPTH = 6;
    localparam int TAG_BITS   = 3;

    // saturation limits of a mapped coordinate
    localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CENTER_RE = 3'd0,
        CFG_CENTER_IM = 3'd1,
        CFG_SPAN_RE   = 3'd2,
        CFG_SPAN_IM   = 3'd3,
        CFG_MAX_ITER  = 3'd4,
        CFG_WIDTH     = 3'd5
    } cfg_idx_t;

    // per-item bookkeeping that travels around the iteration loop
    typedef struct packed {
        logic                  valid;
        logic                  done;
        logic [TAG_BITS-1:0]   tag;
        logic [ITER_BITS-1:0]  it;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic                  in_set;
        logic [FMAG_BITS-1:0]  fmag;
    } ring_ctl_t;

endpackage

// ----- rtl/mbe_coord.sv -----
module mbe_coord (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [mbe_pkg::PIX_BITS-1:0]      pix,
    input  logic [mbe_pkg::COORD_BITS-1:0]    center,
    input  logic [mbe_pkg::SPAN_BITS-1:0]     span,
    input  logic [mbe_pkg::PIX_BITS-1:0]      divisor,
    output logic                              out_valid,
    output logic [mbe_pkg::COORD_BITS-1:0]    coord
);

    localparam int PB         = mbe_pkg::PIX_BITS;
    localparam int NUM_W      = mbe_pkg::PIX_BITS + mbe_pkg::SPAN_BITS;
    localparam int DIV_STEPS  = 6;
    localparam int DIV_STAGES = NUM_W / DIV_STEPS;
    localparam int SUM_W      = NUM_W + 2;

    logic                 v_mul_reg;
    logic [PB+31:0]       pp_lo_reg;
    logic [PB+30:0]       pp_hi_reg;
    logic                 v_num_reg;
    logic [NUM_W-1:0]     num_reg;
    logic                 div_v_reg   [DIV_STAGES];
    logic [PB-1:0]        div_rem_reg [DIV_STAGES];
    logic [NUM_W-1:0]     div_nq_reg  [DIV_STAGES];
    logic                 v_out_reg;
    logic [63:0]          coord_reg;

    logic [PB+31:0]       pp_lo_next;
    logic [PB+30:0]       pp_hi_next;
    logic [NUM_W-1:0]     num_next;
    logic [SUM_W-1:0]     sum_next;
    logic [63:0]          coord_next;

    // pixel times span, split across the span halves
    assign pp_lo_next = {32'd0, pix} * {{PB{1'b0}}, span[31:0]};
    assign pp_hi_next = {31'd0, pix} * {{PB{1'b0}}, span[62:32]};
    assign num_next   = {31'd0, pp_lo_reg} + {pp_hi_reg, 32'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_mul_reg <= 1'b0;
            v_num_reg <= 1'b0;
        end else if (en) begin
            v_mul_reg <= in_valid;
            v_num_reg <= v_mul_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
            num_reg   <= num_next;
        end
    end

    // restoring long division, a few quotient bits per stage
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic             v_in;
        logic [PB-1:0]    rem_in;
        logic [NUM_W-1:0] nq_in;
        logic [PB-1:0]    rem_next;
        logic [NUM_W-1:0] nq_next;

        if (k == 0) begin : g_first
            assign v_in   = v_num_reg;
            assign rem_in = '0;
            assign nq_in  = num_reg;
        end else begin : g_rest
            assign v_in   = div_v_reg[k-1];
            assign rem_in = div_rem_reg[k-1];
            assign nq_in  = div_nq_reg[k-1];
        end

        always_comb begin
            logic [PB:0] cur;
            rem_next = rem_in;
            nq_next  = nq_in;
            for (int i = 0; i < DIV_STEPS; i++) begin
                cur     = {rem_next, nq_next[NUM_W-1]};
                nq_next = {nq_next[NUM_W-2:0], 1'b0};
                if (cur >= {1'b0, divisor}) begin
                    rem_next   = PB'(cur - {1'b0, divisor});
                    nq_next[0] = 1'b1;
                end else begin
                    rem_next = cur[PB-1:0];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                div_v_reg[k] <= 1'b0;
            end else if (en) begin
                div_v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                div_rem_reg[k] <= rem_next;
                div_nq_reg[k]  <= nq_next;
            end
        end
    end

    // center minus half span plus quotient, saturated to 64 bits
    assign sum_next = {{(SUM_W-64){center[63]}}, center}
                    - {{(SUM_W-62){1'b0}}, span[62:1]}
                    + {2'd0, div_nq_reg[DIV_STAGES-1]};

    always_comb begin
        if ((&sum_next[SUM_W-1:63]) || !(|sum_next[SUM_W-1:63])) begin
            coord_next = sum_next[63:0];
        end else if (sum_next[SUM_W-1]) begin
            coord_next = mbe_pkg::COORD_MIN;
        end else begin
            coord_next = mbe_pkg::COORD_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_out_reg <= 1'b0;
        end else if (en) begin
            v_out_reg <= div_v_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            coord_reg <= coord_next;
        end
    end

    assign out_valid = v_out_reg;
    assign coord     = coord_reg;

endmodule

// ----- rtl/mbe_iter.sv -----
module mbe_iter #(
    parameter int COORD_FRAC_BITS = 60
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              new_valid,
    input  logic [mbe_pkg::COORD_BITS-1:0]    new_cx,
    input  logic [mbe_pkg::COORD_BITS-1:0]    new_cy,
    input  logic [mbe_pkg::ITER_BITS-1:0]     max_iter,
    output logic                              take,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              out_in_set,
    output logic [mbe_pkg::ITER_BITS-1:0]     out_count,
    output logic [mbe_pkg::FMAG_BITS-1:0]     out_fmag
);

    localparam int F   = COORD_FRAC_BITS;
    localparam int MB  = ((F + 17 > 64) ? F + 17 : 64) + 1;
    localparam int XW  = MB + 1;
    localparam int NL  = (MB + 31) / 32;
    localparam int LW  = NL * 32;
    localparam int RW  = LW + 32;
    localparam int PWL = 2 * LW;
    localparam int SW  = 2 * MB - F;
    localparam int MW  = SW + 1;
    localparam int EW  = SW + 3;
    localparam int TB  = mbe_pkg::TAG_BITS;
    localparam int D   = mbe_pkg::RING_DEPTH;

    localparam logic [MW-1:0] BAIL = MW'(1) << (16 + F);
    localparam logic [MW-1:0] FOUR = MW'(1) << (2 + F);

    mbe_pkg::ring_ctl_t ctl_reg [D];

    logic [MB-1:0]     ax_reg, ay_reg;
    logic              sneg0_reg, sneg1_reg, sneg2_reg, sneg3_reg;
    logic [63:0]       ppxx_reg [NL][NL];
    logic [63:0]       ppyy_reg [NL][NL];
    logic [63:0]       ppxy_reg [NL][NL];
    logic [RW-1:0]     rxx_reg [NL];
    logic [RW-1:0]     ryy_reg [NL];
    logic [RW-1:0]     rxy_reg [NL];
    logic [SW-1:0]     xx_reg, yy_reg, xy_reg;
    logic [MW-1:0]     mag_reg;
    logic signed [SW:0] dxy_reg, sxy_reg;
    logic [XW-1:0]     x_reg, y_reg;

    logic [TB-1:0]     head_reg, tail_reg;
    logic              m_valid_reg;
    logic              in_set_reg;
    logic [mbe_pkg::ITER_BITS-1:0] cnt_reg;
    logic [mbe_pkg::FMAG_BITS-1:0] fmag_reg;

    logic              out_free, exit_now, slot_free;
    mbe_pkg::ring_ctl_t ent_ctl, s5_next;
    logic [XW-1:0]     ex, ey, ax_full, ay_full;
    logic [LW-1:0]     axp, ayp;
    logic [63:0]       ppxx_next [NL][NL];
    logic [63:0]       ppyy_next [NL][NL];
    logic [63:0]       ppxy_next [NL][NL];
    logic [RW-1:0]     rxx_next [NL];
    logic [RW-1:0]     ryy_next [NL];
    logic [RW-1:0]     rxy_next [NL];
    logic [PWL-1:0]    fxx, fyy, fxy;
    logic              brk;
    logic [EW-1:0]     x_new, y_new;
    logic [MW-1:0]     mag_shift;
    logic [XW-1:0]     x_next, y_next;

    // exit and entry at the loop seam
    assign out_free  = !m_valid_reg || out_ready;
    assign exit_now  = ctl_reg[D-1].valid && ctl_reg[D-1].done
                    && (ctl_reg[D-1].tag == head_reg) && out_free;
    assign slot_free = !ctl_reg[D-1].valid || exit_now;
    assign take      = slot_free && new_valid;

    always_comb begin
        ent_ctl = ctl_reg[D-1];
        ex      = x_reg;
        ey      = y_reg;
        if (take) begin
            ent_ctl       = '0;
            ent_ctl.valid = 1'b1;
            ent_ctl.tag   = tail_reg;
            ent_ctl.cx    = new_cx;
            ent_ctl.cy    = new_cy;
            ex            = '0;
            ey            = '0;
        end else if (exit_now) begin
            ent_ctl.valid = 1'b0;
        end
    end

    // stage 0: magnitudes and product sign
    assign ax_full = ex[XW-1] ? XW'(-ex) : ex;
    assign ay_full = ey[XW-1] ? XW'(-ey) : ey;

    // stage 1: 32-bit limb partial products
    assign axp = LW'(ax_reg);
    assign ayp = LW'(ay_reg);

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            for (int j = 0; j < NL; j++) begin
                ppxx_next[i][j] = 64'(axp[32*i +: 32]) * 64'(axp[32*j +: 32]);
                ppyy_next[i][j] = 64'(ayp[32*i +: 32]) * 64'(ayp[32*j +: 32]);
                ppxy_next[i][j] = 64'(axp[32*i +: 32]) * 64'(ayp[32*j +: 32]);
            end
        end
    end

    // stage 2: row sums
    always_comb begin
        for (int i = 0; i < NL; i++) begin
            rxx_next[i] = '0;
            ryy_next[i] = '0;
            rxy_next[i] = '0;
            for (int j = 0; j < NL; j++) begin
                rxx_next[i] = rxx_next[i] + (RW'(ppxx_reg[i][j]) << (32 * j));
                ryy_next[i] = ryy_next[i] + (RW'(ppyy_reg[i][j]) << (32 * j));
                rxy_next[i] = rxy_next[i] + (RW'(ppxy_reg[i][j]) << (32 * j));
            end
        end
    end

    // stage 3: full products, dropping fraction bits
    always_comb begin
        fxx = '0;
        fyy = '0;
        fxy = '0;
        for (int i = 0; i < NL; i++) begin
            fxx = fxx + (PWL'(rxx_reg[i]) << (32 * i));
            fyy = fyy + (PWL'(ryy_reg[i]) << (32 * i));
            fxy = fxy + (PWL'(rxy_reg[i]) << (32 * i));
        end
    end

    // stage 5: escape test and z update
    assign brk       = (mag_reg > BAIL) || (ctl_reg[D-2].it >= max_iter);
    assign x_new     = EW'(dxy_reg) + EW'($signed(ctl_reg[D-2].cx));
    assign y_new     = (EW'(sxy_reg) <<< 1) + EW'($signed(ctl_reg[D-2].cy));
    assign mag_shift = mag_reg >> (F - 32);

    always_comb begin
        s5_next = ctl_reg[D-2];
        x_next  = x_new[XW-1:0];
        y_next  = y_new[XW-1:0];
        if (s5_next.valid && !s5_next.done) begin
            if (brk) begin
                s5_next.done   = 1'b1;
                s5_next.in_set = (mag_reg <= FOUR);
                s5_next.fmag   = (|mag_shift[MW-1:64]) ? '1 : mag_shift[63:0];
            end else begin
                s5_next.it = s5_next.it + 1'b1;
            end
        end
    end

    // loop control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < D; k++) begin
                ctl_reg[k] <= '0;
            end
        end else begin
            ctl_reg[0] <= ent_ctl;
            for (int k = 1; k < D - 1; k++) begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
            ctl_reg[D-1] <= s5_next;
        end
    end

    // loop datapath registers
    always_ff @(posedge aclk) begin
        ax_reg    <= ax_full[MB-1:0];
        ay_reg    <= ay_full[MB-1:0];
        sneg0_reg <= ex[XW-1] ^ ey[XW-1];
        ppxx_reg  <= ppxx_next;
        ppyy_reg  <= ppyy_next;
        ppxy_reg  <= ppxy_next;
        sneg1_reg <= sneg0_reg;
        rxx_reg   <= rxx_next;
        ryy_reg   <= ryy_next;
        rxy_reg   <= rxy_next;
        sneg2_reg <= sneg1_reg;
        xx_reg    <= SW'(fxx >> F);
        yy_reg    <= SW'(fyy >> F);
        xy_reg    <= SW'(fxy >> F);
        sneg3_reg <= sneg2_reg;
        mag_reg   <= MW'(xx_reg) + MW'(yy_reg);
        dxy_reg   <= $signed({1'b0, xx_reg}) - $signed({1'b0, yy_reg});
        sxy_reg   <= sneg3_reg ? -$signed({1'b0, xy_reg}) : $signed({1'b0, xy_reg});
        x_reg     <= x_next;
        y_reg     <= y_next;
    end

    // order tags and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                tail_reg <= tail_reg + 1'b1;
            end
            if (exit_now) begin
                head_reg    <= head_reg + 1'b1;
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (exit_now) begin
            in_set_reg <= ctl_reg[D-1].in_set;
            cnt_reg    <= ctl_reg[D-1].it;
            fmag_reg   <= ctl_reg[D-1].fmag;
        end
    end

    assign out_valid  = m_valid_reg;
    assign out_in_set = in_set_reg;
    assign out_count  = cnt_reg;
    assign out_fmag   = fmag_reg;

endmodule

// ----- rtl/mandelbrot_escape_iteration.sv -----
// channel | direction | fields (lowest bit first)
// s_      | in        | pixel_x[14:0], pixel_y[29:15]
// m_      | out       | in_set[0], iteration_count[27:1], final_magnitude_sq[91:28]
// cfg_    | in        | register index, 64-bit write data
//
// a pixel passes through the coordinate pipeline (multiply, long division,
// offset), then makes n + 1 passes through the iteration loop, where n is its
// iteration count, or more while an earlier pixel has yet to leave; up to six
// pixels share the loop and results are kept in input order.
// reset is synchronous and active low; it restores the default view.
// a stalled output holds the loop exit; the coordinate pipeline then freezes.
module mandelbrot_escape_iteration #(
    parameter int COORD_FRAC_BITS = 60
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pixel_x, pixel_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // in_set, iteration_count, final_magnitude_sq
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata
);

    localparam int PB = mbe_pkg::PIX_BITS;
    localparam int IB = mbe_pkg::ITER_BITS;

    localparam logic [63:0]   RST_CENTER_RE = -64'sd881984951024237937;
    localparam logic [62:0]   RST_SPAN_RE   = 63'd2847716116378912031;
    localparam logic [62:0]   RST_SPAN_IM   = 63'd2582544170319337226;
    localparam logic [IB-1:0] RST_MAX_ITER  = IB'(1000);
    localparam logic [PB-1:0] RST_WIDTH     = PB'(800);

    logic [63:0]   center_re_reg, center_im_reg;
    logic [62:0]   span_re_reg, span_im_reg;
    logic [IB-1:0] max_iter_reg;
    logic [PB-1:0] width_reg;

    logic [PB-1:0] divisor;
    logic          fe_en, v_re, v_im, fe_valid, take;
    logic [63:0]   c_re, c_im;
    logic          in_set;
    logic [IB-1:0] count;
    logic [63:0]   fmag;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_re_reg <= RST_CENTER_RE;
            center_im_reg <= '0;
            span_re_reg   <= RST_SPAN_RE;
            span_im_reg   <= RST_SPAN_IM;
            max_iter_reg  <= RST_MAX_ITER;
            width_reg     <= RST_WIDTH;
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                mbe_pkg::CFG_CENTER_RE: center_re_reg <= cfg_wdata;
                mbe_pkg::CFG_CENTER_IM: center_im_reg <= cfg_wdata;
                mbe_pkg::CFG_SPAN_RE:   span_re_reg   <= cfg_wdata[62:0];
                mbe_pkg::CFG_SPAN_IM:   span_im_reg   <= cfg_wdata[62:0];
                mbe_pkg::CFG_MAX_ITER:  max_iter_reg  <= cfg_wdata[IB-1:0];
                mbe_pkg::CFG_WIDTH:     width_reg     <= cfg_wdata[PB-1:0];
                default: ;
            endcase
        end
    end

    // width minus one, never below one
    assign divisor = (width_reg < PB'(2)) ? PB'(1) : width_reg - 1'b1;

    // coordinate pipeline advances unless its last item cannot enter the loop
    assign fe_valid = v_re && v_im;
    assign fe_en    = !fe_valid || take;
    assign s_tready = fe_en;

    mbe_coord u_coord_re (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (fe_en),
        .in_valid  (s_tvalid),
        .pix       (s_tdata[PB-1:0]),
        .center    (center_re_reg),
        .span      (span_re_reg),
        .divisor   (divisor),
        .out_valid (v_re),
        .coord     (c_re)
    );

    mbe_coord u_coord_im (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (fe_en),
        .in_valid  (s_tvalid),
        .pix       (s_tdata[2*PB-1:PB]),
        .center    (center_im_reg),
        .span      (span_im_reg),
        .divisor   (divisor),
        .out_valid (v_im),
        .coord     (c_im)
    );

    mbe_iter #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_iter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .new_valid  (fe_valid),
        .new_cx     (c_re),
        .new_cy     (c_im),
        .max_iter   (max_iter_reg),
        .take       (take),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_in_set (in_set),
        .out_count  (count),
        .out_fmag   (fmag)
    );

    assign m_tdata = {4'd0, fmag, count, in_set};

endmodule
